@@ hw/rtl/lcdtt_pkg.sv @@
`default_nettype none

package lcdtt_pkg;

  localparam int MAX_COLUMNS = 6;
  localparam int SEGMENTS    = 14;
  localparam int CHAR_W      = 7;
  localparam int CURSOR_W    = 3;
  localparam int WORD_W      = 30;
  localparam int COMMONS     = 4;
  localparam int GLYPH_COUNT = 95;

  localparam logic [7:0] NEWLINE_CODE       = 8'h0a;
  localparam logic [7:0] FIRST_PRINTABLE    = 8'h20;
  localparam logic [7:0] FIRST_IGNORED_HIGH = 8'h7f;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [SEGMENTS-1:0] glyph_t;
  typedef logic [CURSOR_W-1:0] cursor_t;
  // [6:5] common line, [4:0] segment bit
  typedef logic [6:0]          wire_t;

  localparam char_t SPACE_CHAR = 7'h20;

  // Segments A..Q of each column, as common*32 + segment bit
  localparam wire_t WIRING [MAX_COLUMNS][SEGMENTS] = '{
    '{7'd60, 7'd28, 7'd33, 7'd32, 7'd0,  7'd61, 7'd29,
      7'd125, 7'd124, 7'd92, 7'd1,  7'd96,  7'd64, 7'd93},
    '{7'd58, 7'd26, 7'd39, 7'd34, 7'd2,  7'd59, 7'd27,
      7'd123, 7'd122, 7'd90, 7'd7,  7'd98,  7'd66, 7'd91},
    '{7'd56, 7'd24, 7'd41, 7'd40, 7'd8,  7'd57, 7'd25,
      7'd121, 7'd120, 7'd88, 7'd9,  7'd104, 7'd72, 7'd89},
    '{7'd52, 7'd20, 7'd43, 7'd42, 7'd10, 7'd53, 7'd21,
      7'd117, 7'd116, 7'd84, 7'd11, 7'd106, 7'd74, 7'd85},
    '{7'd50, 7'd18, 7'd45, 7'd44, 7'd12, 7'd51, 7'd19,
      7'd115, 7'd114, 7'd82, 7'd13, 7'd108, 7'd76, 7'd83},
    '{7'd49, 7'd17, 7'd47, 7'd46, 7'd14, 7'd48, 7'd16,
      7'd112, 7'd113, 7'd81, 7'd15, 7'd110, 7'd78, 7'd80}
  };

  // 14-segment font, codes 0x20..0x7e
  localparam glyph_t GLYPHS [GLYPH_COUNT] = '{
    14'h0000, 14'h0208, 14'h0120, 14'h154e, 14'h156d, 14'h2ee4, 14'h2a8d, 14'h0200,
    14'h0a00, 14'h2080, 14'h3fc0, 14'h1540, 14'h2000, 14'h0440, 14'h1000, 14'h2200,
    14'h003f, 14'h0006, 14'h045b, 14'h044f, 14'h0466, 14'h046d, 14'h047d, 14'h0007,
    14'h047f, 14'h046f, 14'h1100, 14'h2100, 14'h0a00, 14'h0448, 14'h2080, 14'h1403,
    14'h053b, 14'h0477, 14'h0a79, 14'h0039, 14'h208f, 14'h0479, 14'h0471, 14'h043d,
    14'h0476, 14'h1109, 14'h001e, 14'h0674, 14'h0038, 14'h0137, 14'h08b6, 14'h013f,
    14'h0473, 14'h083f, 14'h0c73, 14'h046d, 14'h1101, 14'h003e, 14'h2230, 14'h103e,
    14'h06d4, 14'h046e, 14'h2209, 14'h0039, 14'h0880, 14'h000f, 14'h0202, 14'h0008,
    14'h0080, 14'h1058, 14'h047c, 14'h0458, 14'h045e, 14'h2058, 14'h0071, 14'h060e,
    14'h0474, 14'h1001, 14'h000d, 14'h0a70, 14'h1108, 14'h1454, 14'h0454, 14'h045c,
    14'h0271, 14'h0487, 14'h0050, 14'h0c08, 14'h0078, 14'h001c, 14'h0818, 14'h101c,
    14'h2a80, 14'h080c, 14'h2048, 14'h0a40, 14'h1100, 14'h2480, 14'h0452
  };

  function automatic glyph_t glyph_of(input char_t code);
    logic [6:0] idx;
    idx = code - SPACE_CHAR;
    if (code < SPACE_CHAR || code == FIRST_IGNORED_HIGH[CHAR_W-1:0]) begin
      return '0;
    end
    return GLYPHS[idx];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcdtt_render.sv @@
`default_nettype none

module lcdtt_render
  import lcdtt_pkg::*;
#(
  parameter int COLUMNS = MAX_COLUMNS
) (
  input  char_t text    [COLUMNS],
  output word_t commons [COMMONS]
);

  glyph_t glyph [COLUMNS];

  always_comb begin
    for (int col = 0; col < COLUMNS; col++) begin
      glyph[col] = glyph_of(text[col]);
    end
  end

  // OR each lit segment into its wired common/bit
  always_comb begin
    for (int k = 0; k < COMMONS; k++) begin
      commons[k] = '0;
    end
    for (int col = 0; col < COLUMNS; col++) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        if (glyph[col][i]) begin
          commons[WIRING[col][i][6:5]][WIRING[col][i][4:0]] = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/segment_lcd_text_terminal_unit.sv @@
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_char_code[7:0]
// out     | output    | out_valid/out_stall | out_common0_word..out_common3_word[29:0]
//
// One beat per cycle sustained while out_stall stays low; a printable byte's
// result beat passes the input register, then the result register.
// The text state updates in the same cycle as the render from the input
// register, so back-to-back bytes see each other's effect with no bubble.
// Ignored bytes and newlines drain from the input register without needing
// the result register, so they never wait on out_stall.
// rst_n (synchronous) empties both registers and loads spaces, cursor 0,
// newline flag clear.
`default_nettype none

module segment_lcd_text_terminal_unit
  import lcdtt_pkg::*;
#(
  parameter int COLUMNS = MAX_COLUMNS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_char_code,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      word_t       out_common0_word,
  output      word_t       out_common1_word,
  output      word_t       out_common2_word,
  output      word_t       out_common3_word
);

  localparam cursor_t COLS_C = CURSOR_W'(COLUMNS);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_char_r;

  // text state
  char_t   text_r [COLUMNS];
  char_t   text_nxt [COLUMNS];
  cursor_t cursor_r, cursor_nxt;
  logic    nl_r, nl_nxt;

  // result register
  logic  out_valid_r, out_valid_nxt;
  word_t words_r [COMMONS];
  word_t words_nxt [COMMONS];

  // working signals
  logic    printable, is_newline, out_free, proc, show;
  char_t   ch;
  cursor_t cur;
  logic    full;
  char_t   base [COLUMNS];
  char_t   shifted [COLUMNS];

  assign printable  = (in_char_r >= FIRST_PRINTABLE) && (in_char_r < FIRST_IGNORED_HIGH);
  assign is_newline = (in_char_r == NEWLINE_CODE);
  assign ch         = in_char_r[CHAR_W-1:0];
  assign out_free   = !out_valid_r || !out_stall;
  // a byte in the input register retires this cycle
  assign proc       = in_valid_r && (!printable || out_free);
  assign show       = proc && printable;
  assign in_stall   = in_valid_r && !proc;

  // pending newline: blank columns 1.., home cursor, before placing the byte
  always_comb begin
    cur  = nl_r ? '0 : cursor_r;
    full = (cur >= COLS_C);
    for (int i = 0; i < COLUMNS; i++) begin
      base[i] = (nl_r && i != 0) ? SPACE_CHAR : text_r[i];
    end
    for (int i = 0; i < COLUMNS - 1; i++) begin
      shifted[i] = base[i+1];
    end
    shifted[COLUMNS-1] = ch;
    for (int i = 0; i < COLUMNS; i++) begin
      if (full) begin
        text_nxt[i] = shifted[i];
      end else begin
        text_nxt[i] = (CURSOR_W'(i) == cur) ? ch : base[i];
      end
    end
    cursor_nxt = full ? COLS_C : cur + 1'b1;
  end

  lcdtt_render #(
    .COLUMNS (COLUMNS)
  ) u_render (
    .text    (text_nxt),
    .commons (words_nxt)
  );

  always_comb begin
    in_valid_nxt = in_stall ? in_valid_r : in_valid;
    nl_nxt       = nl_r;
    if (proc && is_newline) begin
      nl_nxt = 1'b1;
    end else if (show) begin
      nl_nxt = 1'b0;
    end
    if (show) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nl_r        <= 1'b0;
      cursor_r    <= '0;
      for (int i = 0; i < COLUMNS; i++) begin
        text_r[i] <= SPACE_CHAR;
      end
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      nl_r        <= nl_nxt;
      if (show) begin
        cursor_r <= cursor_nxt;
        for (int i = 0; i < COLUMNS; i++) begin
          text_r[i] <= text_nxt[i];
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char_code;
    end
    if (show) begin
      for (int k = 0; k < COMMONS; k++) begin
        words_r[k] <= words_nxt[k];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_common0_word = words_r[0];
  assign out_common1_word = words_r[1];
  assign out_common2_word = words_r[2];
  assign out_common3_word = words_r[3];

  // cursor never runs past the full mark
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= COLS_C)
    else $error("cursor beyond column count");

  // a printable byte always yields a result beat next cycle
  a_show_beat: assert property (@(posedge clk) disable iff (!rst_n)
    show |=> out_valid)
    else $error("printable byte gave no result beat");

  // ignored byte or newline must not create a beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !printable) |=> (out_valid == $past(out_valid_r && out_stall)))
    else $error("non-printable byte produced a beat");

  // pending newline is consumed by the next printable byte
  a_nl_clear: assert property (@(posedge clk) disable iff (!rst_n)
    show |=> !nl_r)
    else $error("newline flag survived a printable byte");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import lcdtt_pkg::*;

  // Display width under test; the model below follows the same value.
  localparam int COLS         = MAX_COLUMNS;
  localparam int CYCLE_LIMIT  = 400000;
  // Result beat passes the input and result registers; leave some slack.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BYTES = 880;

  // Common line of segments A..Q; identical for every column.
  localparam int SEG_COMMON [SEGMENTS] = '{1, 0, 1, 1, 0, 1, 0, 3, 3, 2, 0, 3, 2, 2};

  // Segment bit of segments A..Q, per column.
  localparam int SEG_BIT [MAX_COLUMNS][SEGMENTS] = '{
    '{28, 28,  1,  0,  0, 29, 29, 29, 28, 28,  1,  0,  0, 29},
    '{26, 26,  7,  2,  2, 27, 27, 27, 26, 26,  7,  2,  2, 27},
    '{24, 24,  9,  8,  8, 25, 25, 25, 24, 24,  9,  8,  8, 25},
    '{20, 20, 11, 10, 10, 21, 21, 21, 20, 20, 11, 10, 10, 21},
    '{18, 18, 13, 12, 12, 19, 19, 19, 18, 18, 13, 12, 12, 19},
    '{17, 17, 15, 14, 14, 16, 16, 16, 17, 17, 15, 14, 14, 16}
  };

  // 14-segment character set, space to tilde.
  localparam logic [13:0] FONT [GLYPH_COUNT] = '{
    14'h0000, 14'h0208, 14'h0120, 14'h154e, 14'h156d, 14'h2ee4, 14'h2a8d, 14'h0200,
    14'h0a00, 14'h2080, 14'h3fc0, 14'h1540, 14'h2000, 14'h0440, 14'h1000, 14'h2200,
    14'h003f, 14'h0006, 14'h045b, 14'h044f, 14'h0466, 14'h046d, 14'h047d, 14'h0007,
    14'h047f, 14'h046f, 14'h1100, 14'h2100, 14'h0a00, 14'h0448, 14'h2080, 14'h1403,
    14'h053b, 14'h0477, 14'h0a79, 14'h0039, 14'h208f, 14'h0479, 14'h0471, 14'h043d,
    14'h0476, 14'h1109, 14'h001e, 14'h0674, 14'h0038, 14'h0137, 14'h08b6, 14'h013f,
    14'h0473, 14'h083f, 14'h0c73, 14'h046d, 14'h1101, 14'h003e, 14'h2230, 14'h103e,
    14'h06d4, 14'h046e, 14'h2209, 14'h0039, 14'h0880, 14'h000f, 14'h0202, 14'h0008,
    14'h0080, 14'h1058, 14'h047c, 14'h0458, 14'h045e, 14'h2058, 14'h0071, 14'h060e,
    14'h0474, 14'h1001, 14'h000d, 14'h0a70, 14'h1108, 14'h1454, 14'h0454, 14'h045c,
    14'h0271, 14'h0487, 14'h0050, 14'h0c08, 14'h0078, 14'h001c, 14'h0818, 14'h101c,
    14'h2a80, 14'h080c, 14'h2048, 14'h0a40, 14'h1100, 14'h2480, 14'h0452
  };

  // Four common words as seen on the result beat.
  typedef struct packed {
    word_t com0;
    word_t com1;
    word_t com2;
    word_t com3;
  } lcd_frame_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  word_t      out_common0_word;
  word_t      out_common1_word;
  word_t      out_common2_word;
  word_t      out_common3_word;

  // Bytes waiting for the driver, and frames waiting for the monitor.
  logic [7:0] pending_bytes [$];
  lcd_frame_t expected_frames [$];

  // Shadow of the display text, cursor and newline flag.
  char_t      shadow_text [MAX_COLUMNS];
  cursor_t    shadow_cursor;
  logic       shadow_newline;

  int cycle_count    = 0;
  int mismatches     = 0;
  int frames_checked = 0;
  int bytes_sent     = 0;
  int quiet_bytes    = 0;
  int scroll_count   = 0;
  int restart_count  = 0;
  int send_gap       = 0;
  int send_calm      = 0;
  int stall_left     = 0;
  int stall_calm     = 0;

  segment_lcd_text_terminal_unit #(.COLUMNS(COLS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_common0_word (out_common0_word),
    .out_common1_word (out_common1_word),
    .out_common2_word (out_common2_word),
    .out_common3_word (out_common3_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Idle length for either side: mostly none or short, now and then long,
  // plus calm stretches where nothing idles at all.
  function automatic int idle_span(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Decode the whole shadow text through the font and the pad wiring.
  function automatic lcd_frame_t paint_frame();
    word_t       words [4];
    logic [13:0] glyph;
    lcd_frame_t  frame;
    for (int k = 0; k < 4; k++) words[k] = '0;
    for (int c = 0; c < COLS; c++) begin
      glyph = FONT[shadow_text[c] - SPACE_CHAR];
      for (int s = 0; s < SEGMENTS; s++) begin
        if (glyph[s]) words[SEG_COMMON[s]][SEG_BIT[c][s]] = 1'b1;
      end
    end
    frame.com0 = words[0];
    frame.com1 = words[1];
    frame.com2 = words[2];
    frame.com3 = words[3];
    return frame;
  endfunction

  // Apply one accepted byte to the shadow; printable bytes queue a frame.
  function automatic void advance_terminal(input logic [7:0] code);
    if (code < FIRST_PRINTABLE || code >= FIRST_IGNORED_HIGH) begin
      // newline only arms the flag, everything else here is dropped
      if (code == NEWLINE_CODE) shadow_newline = 1'b1;
      quiet_bytes++;
      return;
    end
    if (shadow_newline) begin
      // first printable after a newline: keep column 0, blank the rest
      for (int c = 1; c < COLS; c++) shadow_text[c] = SPACE_CHAR;
      shadow_cursor  = '0;
      shadow_newline = 1'b0;
      restart_count++;
    end
    if (shadow_cursor < COLS) begin
      shadow_text[shadow_cursor] = code[CHAR_W-1:0];
      shadow_cursor              = shadow_cursor + 1'b1;
    end else begin
      // full line: shift left, new character lands in the last column
      for (int c = 0; c + 1 < COLS; c++) shadow_text[c] = shadow_text[c+1];
      shadow_text[COLS-1] = code[CHAR_W-1:0];
      scroll_count++;
    end
    expected_frames.push_back(paint_frame());
  endfunction

  task automatic check_word(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $error("%s: expected %08h, got %08h", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver. A beat goes at an edge with valid high and stall low;
  // a stalled beat is held untouched, and valid is only lowered for a gap or when no bytes are pending.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_terminal(in_char_code);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid     <= 1'b1;
          in_char_code <= pending_bytes.pop_front();
          send_gap     <= idle_span(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each beat against the oldest expected frame,
  // with random back-pressure driven on out_stall.
  always @(posedge clk) begin
    lcd_frame_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("result beat with no frame expected");
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          check_word("out_common0_word", want.com0, out_common0_word);
          check_word("out_common1_word", want.com1, out_common1_word);
          check_word("out_common2_word", want.com2, out_common2_word);
          check_word("out_common3_word", want.com3, out_common3_word);
          frames_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= idle_span(stall_calm);
      end
    end
  end

  initial begin
    // Opening sequence: control and high bytes that must be dropped, the
    // printable extremes, a full line then two scrolls, a repeated newline,
    // an ignored byte while the flag is armed, and line restarts.
    logic [7:0] opening [21] = '{
      8'h00, 8'h41, 8'h20, 8'h7e, 8'h1f, 8'h7f, 8'h80, 8'hff,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h0a, 8'h0a, 8'h09, 8'h58, 8'h59, 8'h0a, 8'h0d, 8'h21
    };
    int  roll;
    bit  timed_out;

    for (int c = 0; c < MAX_COLUMNS; c++) shadow_text[c] = SPACE_CHAR;
    shadow_cursor  = '0;
    shadow_newline = 1'b0;

    foreach (opening[k]) pending_bytes.push_back(opening[k]);

    // Mostly text with newlines, so lines fill, scroll and restart;
    // the rest is any byte at all.
    for (int n = 0; n < RANDOM_BYTES; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8)       pending_bytes.push_back(NEWLINE_CODE);
      else if (roll < 22) pending_bytes.push_back(8'($urandom_range(0, 255)));
      else                pending_bytes.push_back(8'($urandom_range(32'h20, 32'h7e)));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sample away from the active edge so counters and queues are settled.
    while ((pending_bytes.size() != 0 || in_valid || expected_frames.size() != 0)
           && cycle_count < CYCLE_LIMIT) begin
      @(negedge clk);
    end
    timed_out = (cycle_count >= CYCLE_LIMIT);

    if (timed_out) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb NOT OK");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (expected_frames.size() != 0) begin
        $error("%0d expected frames never arrived", expected_frames.size());
        mismatches++;
      end
      $display("sent %0d bytes (%0d dropped or newline), compared %0d frames",
               bytes_sent, quiet_bytes, frames_checked);
      $display("%0d scrolls on a full line, %0d restarts after newline, %0d mismatches",
               scroll_count, restart_count, mismatches);
      if (mismatches == 0) begin
        $display("tb OK");
      end else begin
        $display("tb NOT OK");
      end
    end
    $finish;
  end

endmodule
